// File: sv/rrclf_pkg.sv
`timescale 1ns / 1ps

package rrclf_pkg;

	// Line geometry
	localparam logic [31:0] LINE_BYTES = 32'd4096;
	localparam logic [31:0] FILL_ALIGN = 32'd512;
	localparam logic [31:0] ALIGN_MASK = FILL_ALIGN - 32'd1;

	// Result field widths
	localparam int SLOT_W  = 6;
	localparam int DELTA_W = 12;
	localparam int FLEN_W  = 13;

	// Source modes
	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_MEMORY = 2'd1;
	localparam logic [1:0] MODE_FILE   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_SOURCE_MODE  = 2'd0;
	localparam logic [1:0] CFG_ROM_SIZE     = 2'd1;
	localparam logic [1:0] CFG_CACHE_ENABLE = 2'd2;

	typedef enum logic [2:0] {
		ST_RANGE_ERR = 3'd0,
		ST_EMPTY_OK  = 3'd1,
		ST_MEM_DIRECT = 3'd2,
		ST_HIT       = 3'd3,
		ST_FILLED    = 3'd4,
		ST_FILL_FAIL = 3'd5,
		ST_UNCACHED  = 3'd6
	} status_t;

	// Tag lookup answer
	typedef struct packed {
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic [DELTA_W-1:0]  delta;
		logic [SLOT_W-1:0]   victim;
	} lookup_t;

	// Tag commit into the victim slot
	typedef struct packed {
		logic        en;
		logic        ok;
		logic [31:0] start;
		logic [32:0] line_end;
	} commit_t;

endpackage

// File: sv/rom_read_cache_lookup_fill.sv
`timescale 1ns / 1ps
// Pipeline: a request is captured in the input register and its result in the
// result register, with done high for a single cycle per result.
// Throughput: one request per cycle; busy stays low, the tag lookup and the
// fill commit both finish in the single stage after the input register.
// Reset: arst_n clears configuration, all line tags and the victim pointer.
module rom_read_cache_lookup_fill #(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// request transaction
	input  logic        start,
	output logic        busy,
	input  logic [31:0] read_offset,
	input  logic [31:0] read_length,
	input  logic        fill_ok,
	// result transaction
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  slot,
	output logic [11:0] line_delta,
	output logic [31:0] fill_start,
	output logic [12:0] fill_length
);

	// Configuration registers
	logic [1:0]  source_mode_q;
	logic [31:0] rom_size_q;
	logic        cache_enable_q;

	// Input register
	logic        valid_s1;
	logic [31:0] off_s1;
	logic [31:0] len_s1;
	logic [32:0] end_s1;
	logic        ok_s1;

	// Result register
	logic        done_q;
	rrclf_pkg::status_t status_q;
	logic [5:0]  slot_q;
	logic [11:0] delta_q;
	logic [31:0] fstart_q;
	logic [12:0] flen_q;

	rrclf_pkg::lookup_t lookup;
	rrclf_pkg::commit_t commit;

	logic        range_err;
	logic        cached;
	logic [31:0] aligned;
	logic [31:0] align_delta;
	logic        fits;
	logic [31:0] fstart;
	logic [11:0] fdelta;
	logic [31:0] remain;
	logic [12:0] flen;

	rrclf_pkg::status_t status_d;
	logic [5:0]  slot_d;
	logic [11:0] delta_d;
	logic [31:0] fstart_d;
	logic [12:0] flen_d;

	// The stage never holds a request, so busy is tied low.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q  <= rrclf_pkg::MODE_NONE;
			rom_size_q     <= '0;
			cache_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rrclf_pkg::CFG_SOURCE_MODE:  source_mode_q  <= cfg_wdata[1:0];
				rrclf_pkg::CFG_ROM_SIZE:     rom_size_q     <= cfg_wdata;
				rrclf_pkg::CFG_CACHE_ENABLE: cache_enable_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Capture the request; precompute its end so the range check is a single
	// 33-bit compare and the tag compares use the end directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			off_s1 <= read_offset;
			len_s1 <= read_length;
			end_s1 <= {1'b0, read_offset} + {1'b0, read_length};
			ok_s1  <= fill_ok;
		end
	end

	rrclf_tags #(
		.SLOTS(SLOTS)
	) u_tags (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_offset(off_s1),
		.req_end   (end_s1),
		.commit    (commit),
		.lookup    (lookup)
	);

	// Classify: offset + length past the store end covers both range errors.
	assign range_err = (source_mode_q == rrclf_pkg::MODE_NONE)
		|| (source_mode_q == rrclf_pkg::MODE_UNUSED)
		|| (end_s1 > {1'b0, rom_size_q});
	assign cached = !range_err && (len_s1 != '0)
		&& (source_mode_q == rrclf_pkg::MODE_FILE)
		&& cache_enable_q && (len_s1 <= rrclf_pkg::LINE_BYTES);

	// Fill window: align down, unless the request then overruns the line.
	always_comb begin
		aligned     = off_s1 & ~rrclf_pkg::ALIGN_MASK;
		align_delta = off_s1 & rrclf_pkg::ALIGN_MASK;
		fits = ({1'b0, align_delta} + {1'b0, len_s1}) <= {1'b0, rrclf_pkg::LINE_BYTES};
		fstart = fits ? aligned : off_s1;
		fdelta = fits ? align_delta[11:0] : 12'd0;
		remain = rom_size_q - fstart;
		flen   = (remain < rrclf_pkg::LINE_BYTES) ? remain[12:0]
			: rrclf_pkg::LINE_BYTES[12:0];
	end

	// Commit on every cached miss; the tag block clears the slot on a failed fill.
	always_comb begin
		commit.en       = valid_s1 && cached && !lookup.hit;
		commit.ok       = ok_s1;
		commit.start    = fstart;
		commit.line_end = {1'b0, fstart} + 33'(flen);
	end

	always_comb begin
		slot_d   = '0;
		delta_d  = '0;
		fstart_d = '0;
		flen_d   = '0;
		if (range_err) begin
			status_d = rrclf_pkg::ST_RANGE_ERR;
		end else if (len_s1 == '0) begin
			status_d = rrclf_pkg::ST_EMPTY_OK;
		end else if (source_mode_q == rrclf_pkg::MODE_MEMORY) begin
			status_d = rrclf_pkg::ST_MEM_DIRECT;
		end else if (!cached) begin
			status_d = rrclf_pkg::ST_UNCACHED;
		end else if (lookup.hit) begin
			status_d = rrclf_pkg::ST_HIT;
			slot_d   = lookup.slot;
			delta_d  = lookup.delta;
		end else begin
			status_d = ok_s1 ? rrclf_pkg::ST_FILLED : rrclf_pkg::ST_FILL_FAIL;
			slot_d   = lookup.victim;
			delta_d  = fdelta;
			fstart_d = fstart;
			flen_d   = flen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			delta_q  <= delta_d;
			fstart_q <= fstart_d;
			flen_q   <= flen_d;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign line_delta  = delta_q;
	assign fill_start  = fstart_q;
	assign fill_length = flen_q;

endmodule

// File: sv/rrclf_tags.sv
`timescale 1ns / 1ps

module rrclf_tags #(
	parameter int SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         req_offset,
	input  logic [32:0]         req_end,
	input  rrclf_pkg::commit_t  commit,
	output rrclf_pkg::lookup_t  lookup
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Tags hold start and end (start + bytes); a cleared line has end == start.
	logic [31:0] start_q [SLOTS];
	logic [32:0] end_q   [SLOTS];
	logic [SW-1:0] victim_q;

	logic [SLOTS-1:0] hit_vec;
	logic [rrclf_pkg::DELTA_W-1:0] dlt [SLOTS];
	logic [SW-1:0] sel;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = (req_offset >= start_q[i]) && (req_end <= end_q[i]);
			dlt[i]     = req_offset[rrclf_pkg::DELTA_W-1:0]
				- start_q[i][rrclf_pkg::DELTA_W-1:0];
		end
	end

	// First matching slot wins
	always_comb begin
		sel = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				sel = SW'(i);
			end
		end
	end

	always_comb begin
		lookup.hit    = |hit_vec;
		lookup.slot   = rrclf_pkg::SLOT_W'(sel);
		lookup.delta  = dlt[sel];
		lookup.victim = rrclf_pkg::SLOT_W'(victim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				start_q[i] <= '0;
				end_q[i]   <= '0;
			end
			victim_q <= '0;
		end else if (commit.en) begin
			if (commit.ok) begin
				start_q[victim_q] <= commit.start;
				end_q[victim_q]   <= commit.line_end;
				victim_q <= (victim_q == SW'(SLOTS - 1)) ? '0 : victim_q + 1'b1;
			end else begin
				// drop the line: zero length, victim pointer holds
				end_q[victim_q] <= {1'b0, start_q[victim_q]};
			end
		end
	end

endmodule

// File: bench/rom_read_cache_lookup_fill_tb.sv
`timescale 1ns / 1ps

module rom_read_cache_lookup_fill_tb;

	localparam int N_SLOTS = 8;
	// Settle cycles after the last result before a register write or a pause ends
	localparam int SETTLE_CYCLES = 3;
	// cfg_index value that maps to no register; writes to it must change nothing
	localparam logic [1:0] CFG_NO_REG = 2'd3;
	localparam int READ_TARGET = 1500;

	typedef enum logic [1:0] {
		OP_READ,
		OP_WRITE,
		OP_PAUSE
	} plan_kind_t;

	// One planned step for the driver: a read transaction, a register write
	// or a pause until every outstanding result has come back
	typedef struct {
		plan_kind_t  kind;
		logic [31:0] off;
		logic [31:0] len;
		logic        ok;
		bit          idle_ok;
		logic [1:0]  idx;
		logic [31:0] data;
	} plan_op_t;

	// Expected answer to one read transaction
	typedef struct packed {
		rrclf_pkg::status_t st;
		logic [5:0]  slot;
		logic [11:0] delta;
		logic [31:0] fstart;
		logic [12:0] flen;
	} lookup_answer_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = rrclf_pkg::CFG_SOURCE_MODE;
	logic [31:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] read_offset = '0;
	logic [31:0] read_length = '0;
	logic        fill_ok = 1'b0;
	logic        done;
	logic [2:0]  status;
	logic [5:0]  slot;
	logic [11:0] line_delta;
	logic [31:0] fill_start;
	logic [12:0] fill_length;

	rom_read_cache_lookup_fill #(
		.SLOTS(N_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.read_offset(read_offset),
		.read_length(read_length),
		.fill_ok(fill_ok),
		.done(done),
		.status(status),
		.slot(slot),
		.line_delta(line_delta),
		.fill_start(fill_start),
		.fill_length(fill_length)
	);

	// Shadow copy of the block: configuration, line tags and victim pointer
	logic [1:0]  model_mode = rrclf_pkg::MODE_NONE;
	logic [31:0] model_size = '0;
	logic        model_cache = 1'b0;
	logic [31:0] line_base [N_SLOTS] = '{default: '0};
	logic [31:0] line_len [N_SLOTS] = '{default: '0};
	logic [2:0]  victim_ptr = '0;

	plan_op_t       request_plan [$];
	lookup_answer_t lookup_answers_q [$];

	int  mismatches = 0;
	int  planned_reads = 0;
	bit  plan_idle_ok = 1'b0;
	bit  plan_done = 1'b0;
	int  gap_left = 0;
	int  quiet_cycles = 0;
	plan_op_t op;
	logic next_start;
	logic next_we;
	lookup_answer_t want;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs or never answers
	initial begin
		#(5_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic logic [31:0] lim(logic [31:0] a, logic [31:0] b);
		return (a < b) ? a : b;
	endfunction

	// Work out the answer to one read and advance the shadow tags the way the
	// block must: first covering slot wins, a miss fills or clears the victim
	function automatic lookup_answer_t predict_lookup(logic [31:0] off, logic [31:0] len,
			logic ok);
		lookup_answer_t a;
		logic [31:0] d;
		logic [31:0] base;
		logic [31:0] delta;
		logic [31:0] remain;
		logic [31:0] flen;
		logic [2:0]  vic;
		bit          found;
		a = '0;
		found = 1'b0;
		if (model_mode == rrclf_pkg::MODE_NONE || model_mode == rrclf_pkg::MODE_UNUSED
				|| off > model_size || len > model_size - off) begin
			a.st = rrclf_pkg::ST_RANGE_ERR;
		end else if (len == 32'd0) begin
			a.st = rrclf_pkg::ST_EMPTY_OK;
		end else if (model_mode == rrclf_pkg::MODE_MEMORY) begin
			a.st = rrclf_pkg::ST_MEM_DIRECT;
		end else if (!model_cache || len > rrclf_pkg::LINE_BYTES) begin
			a.st = rrclf_pkg::ST_UNCACHED;
		end else begin
			for (int i = 0; i < N_SLOTS; i++) begin
				if (!found && off >= line_base[i]) begin
					d = off - line_base[i];
					if (d <= line_len[i] && len <= line_len[i] - d) begin
						found = 1'b1;
						a.st = rrclf_pkg::ST_HIT;
						a.slot = 6'(i);
						a.delta = d[11:0];
					end
				end
			end
			if (!found) begin
				// Align the fill down; fall back to the request offset if it would
				// not fit in one line from the aligned start
				base = off & ~rrclf_pkg::ALIGN_MASK;
				delta = off - base;
				if (delta > rrclf_pkg::LINE_BYTES
						|| len > rrclf_pkg::LINE_BYTES - delta) begin
					base = off;
					delta = '0;
				end
				remain = model_size - base;
				flen = lim(remain, rrclf_pkg::LINE_BYTES);
				vic = victim_ptr;
				a.slot = {3'b000, vic};
				a.delta = delta[11:0];
				a.fstart = base;
				a.flen = flen[12:0];
				if (ok) begin
					a.st = rrclf_pkg::ST_FILLED;
					line_base[vic] = base;
					line_len[vic] = flen;
					victim_ptr = vic + 3'd1;
				end else begin
					// Failed fill drops the victim line but keeps the pointer
					a.st = rrclf_pkg::ST_FILL_FAIL;
					line_len[vic] = '0;
				end
			end
		end
		return a;
	endfunction

	task automatic plan_read(logic [31:0] off, logic [31:0] len, logic ok);
		plan_op_t p;
		p = '{kind: OP_READ, off: off, len: len, ok: ok, idle_ok: plan_idle_ok,
			idx: rrclf_pkg::CFG_SOURCE_MODE, data: '0};
		request_plan.push_back(p);
		planned_reads++;
	endtask

	task automatic plan_write(logic [1:0] idx, logic [31:0] data);
		plan_op_t p;
		p = '{kind: OP_WRITE, off: '0, len: '0, ok: 1'b0, idle_ok: 1'b0, idx: idx, data: data};
		request_plan.push_back(p);
	endtask

	task automatic plan_pause();
		plan_op_t p;
		p = '{kind: OP_PAUSE, off: '0, len: '0, ok: 1'b0, idle_ok: 1'b0,
			idx: rrclf_pkg::CFG_SOURCE_MODE, data: '0};
		request_plan.push_back(p);
	endtask

	// Driver: issue planned steps one at a time. Predict each read at the edge
	// that accepts it, hold start while busy, and only touch the registers
	// once every expected result has arrived and the pipe has settled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			gap_left = 0;
			quiet_cycles = 0;
		end else begin
			next_start = 1'b0;
			next_we = 1'b0;
			if (start && !busy) begin
				lookup_answers_q.push_back(predict_lookup(read_offset, read_length, fill_ok));
			end
			if (start && busy) begin
				// Hold the transaction until the block takes it
				next_start = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (request_plan.size() == 0) begin
				plan_done = 1'b1;
			end else begin
				op = request_plan[0];
				if (op.kind == OP_READ) begin
					op = request_plan.pop_front();
					read_offset <= op.off;
					read_length <= op.len;
					fill_ok <= op.ok;
					next_start = 1'b1;
					if (op.idle_ok && $urandom_range(3, 0) == 0) begin
						gap_left = $urandom_range(6, 1);
					end
				end else if (lookup_answers_q.size() != 0) begin
					quiet_cycles = 0;
				end else if (quiet_cycles < SETTLE_CYCLES) begin
					quiet_cycles++;
				end else begin
					op = request_plan.pop_front();
					quiet_cycles = 0;
					if (op.kind == OP_WRITE) begin
						next_we = 1'b1;
						cfg_index <= op.idx;
						cfg_wdata <= op.data;
						// Nothing is in flight, so update the shadow settings now
						case (op.idx)
							rrclf_pkg::CFG_SOURCE_MODE:  model_mode = op.data[1:0];
							rrclf_pkg::CFG_ROM_SIZE:     model_size = op.data;
							rrclf_pkg::CFG_CACHE_ENABLE: model_cache = op.data[0];
							default: ;
						endcase
					end
				end
			end
			start <= next_start;
			cfg_we <= next_we;
		end
	end

	// Monitor: every done cycle carries one result; check it against the oldest
	// expectation field by field
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lookup_answers_q.size() == 0) begin
				flag_mismatch("result with no read pending", {29'd0, status}, '0);
			end else begin
				want = lookup_answers_q.pop_front();
				if (status !== want.st)
					flag_mismatch("status", {29'd0, status}, {29'd0, want.st});
				if (slot !== want.slot)
					flag_mismatch("slot", {26'd0, slot}, {26'd0, want.slot});
				if (line_delta !== want.delta)
					flag_mismatch("line_delta", {20'd0, line_delta}, {20'd0, want.delta});
				if (fill_start !== want.fstart)
					flag_mismatch("fill_start", fill_start, want.fstart);
				if (fill_length !== want.flen)
					flag_mismatch("fill_length", {19'd0, fill_length}, {19'd0, want.flen});
			end
		end
	end

	initial begin
		logic [1:0]  mode;
		logic [31:0] size;
		logic        cache;
		logic [31:0] span;
		logic [31:0] base;
		logic [31:0] off;
		logic [31:0] len;
		logic [31:0] room;
		int          r;
		int          n;
		int          guard;

		// Directed part: no-source and unused modes, range edges, empty reads,
		// memory view, uncached and oversized reads, fills, hits and a failed fill
		plan_idle_ok = 1'b1;
		plan_read(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		plan_read(32'd0, 32'd0, 1'b0);
		plan_write(rrclf_pkg::CFG_SOURCE_MODE, {30'd0, rrclf_pkg::MODE_MEMORY});
		plan_write(rrclf_pkg::CFG_ROM_SIZE, 32'h0001_0000);
		plan_read(32'd0, 32'd0, 1'b1);
		plan_read(32'h100, 32'h10, 1'b0);
		plan_read(32'h1_0000, 32'd0, 1'b1);
		plan_read(32'h1_0001, 32'd0, 1'b1);
		plan_read(32'hFFFF, 32'd2, 1'b1);
		plan_write(rrclf_pkg::CFG_SOURCE_MODE, {30'h3FFF_FFFF, rrclf_pkg::MODE_UNUSED});
		plan_read(32'd0, 32'd0, 1'b1);
		plan_write(rrclf_pkg::CFG_SOURCE_MODE, {30'd0, rrclf_pkg::MODE_FILE});
		plan_read(32'h20, 32'h10, 1'b1);
		plan_write(rrclf_pkg::CFG_CACHE_ENABLE, 32'd1);
		plan_write(CFG_NO_REG, 32'hFFFF_FFFF);
		plan_read(32'h1234, 32'h10, 1'b0);
		plan_read(32'h1234, 32'h10, 1'b1);
		plan_read(32'h1234, 32'h10, 1'b1);
		plan_read(32'h21FF, 32'd1, 1'b1);
		plan_read(32'h1000, 32'h200, 1'b1);
		plan_read(32'h1FF0, 32'h1001, 1'b1);
		plan_read(32'h3100, 32'h1000, 1'b1);
		plan_read(32'hFFF0, 32'h10, 1'b1);
		plan_read(32'hFE00, 32'h200, 1'b1);
		plan_pause();
		plan_write(rrclf_pkg::CFG_ROM_SIZE, 32'hFFFF_FFFF);
		plan_read(32'hFFFF_FFFF, 32'd0, 1'b1);
		plan_read(32'hFFFF_FFF0, 32'hF, 1'b1);
		plan_read(32'd0, 32'hFFFF_FFFF, 1'b1);
		plan_write(rrclf_pkg::CFG_ROM_SIZE, 32'd0);
		plan_read(32'd0, 32'd0, 1'b1);
		plan_read(32'd0, 32'd1, 1'b1);

		// Random part: phases with fresh settings, reads clustered around a
		// working region so lines get reused and evicted
		while (planned_reads < READ_TARGET) begin
			r = $urandom_range(99, 0);
			mode = (r < 72) ? rrclf_pkg::MODE_FILE : (r < 84) ? rrclf_pkg::MODE_MEMORY :
				(r < 92) ? rrclf_pkg::MODE_NONE : rrclf_pkg::MODE_UNUSED;
			r = $urandom_range(9, 0);
			case (r)
				0: size = 32'd0;
				1: size = 32'hFFFF_FFFF;
				2: size = $urandom;
				3, 4: size = $urandom_range(32'h2000, 1);
				default: size = $urandom_range(32'h4_0000, 32'h1000);
			endcase
			cache = ($urandom_range(7, 0) != 0);
			plan_write(rrclf_pkg::CFG_ROM_SIZE, size);
			plan_write(rrclf_pkg::CFG_SOURCE_MODE,
				{30'($urandom_range(32'h3FFF_FFFF, 0)), mode});
			plan_write(rrclf_pkg::CFG_CACHE_ENABLE,
				{31'($urandom_range(32'h7FFF_FFFF, 0)), cache});
			// Drop idling in the last stretch and in some phases
			plan_idle_ok = (planned_reads < READ_TARGET - 150) && ($urandom_range(3, 0) != 0);
			span = lim(size, 32'h3000);
			base = $urandom_range(size - span, 0);
			n = $urandom_range(120, 40);
			repeat (n) begin
				if ($urandom_range(9, 0) == 0)
					base = $urandom_range(size - span, 0);
				if ($urandom_range(149, 0) == 0)
					plan_pause();
				off = base + $urandom_range(span, 0);
				room = size - off;
				r = $urandom_range(99, 0);
				if (r < 6) begin
					off = $urandom;
					len = $urandom;
				end else if (r < 10) begin
					len = room + $urandom_range(4, 1);
				end else if (r < 14) begin
					len = room;
				end else if (r < 20) begin
					len = lim(room, rrclf_pkg::LINE_BYTES + $urandom_range(64, 1));
				end else if (r < 55) begin
					len = $urandom_range(lim(room, 32'd64), 0);
				end else begin
					len = $urandom_range(lim(room, rrclf_pkg::LINE_BYTES), 0);
				end
				plan_read(off, len, $urandom_range(7, 0) != 0);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (plan_done);
		guard = 0;
		while (lookup_answers_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		// Let the pipe run dry so any stray result shows up
		repeat (8) @(posedge clk);
		if (lookup_answers_q.size() != 0)
			flag_mismatch("results never delivered", 32'(lookup_answers_q.size()), '0);

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
